>>> hdl/dhoat_pkg.sv
// Shared types and constants of the double-hash open-address table.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package dhoat_pkg;

  localparam int unsigned REQ_W  = 2;
  localparam int unsigned HASH_W = 31;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned STAT_W = 2;

  localparam int unsigned OUT_STATUS_LSB = 0;
  localparam int unsigned OUT_FOUND_BIT  = STAT_W;
  localparam int unsigned OUT_TOTAL_LSB  = STAT_W + 1;
  localparam int unsigned OUT_W          = ((STAT_W + 1 + CNT_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] NUM_SLOTS_RST = 11'd1024;

  localparam int unsigned MOD_W         = 32;
  localparam int unsigned MOD_STEP_BITS = 4;
  localparam int unsigned MOD_STEPS     = MOD_W / MOD_STEP_BITS;
  localparam int unsigned MOD_CNT_W     = $clog2(MOD_STEPS);

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_GONE  = 2'd2
  } mark_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_DUP  = 2'd1,
    STATUS_FAIL = 2'd2
  } status_e;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rem;
  } mod_res_t;

endpackage

`default_nettype wire

>>> hdl/dhoat_mod_unit.sv
// Iterative remainder unit: reduces a hash modulo the active slot count,
// four dividend bits per cycle. Depends on dhoat_pkg.
`default_nettype none

module dhoat_mod_unit import dhoat_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [HASH_W-1:0] dividend_i,
  input  wire logic [CNT_W-1:0]  divisor_i,
  output mod_res_t               res_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [MOD_CNT_W-1:0] cnt_q, cnt_d;
  logic [MOD_W-1:0]     shift_q, shift_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]     div_q, div_d;
  logic [CNT_W-1:0]     step_rem;

  always_comb begin
    logic [CNT_W:0]   trial;
    logic [CNT_W-1:0] r;
    r = rem_q;
    for (int j = 0; j < int'(MOD_STEP_BITS); j++) begin
      trial = {r, shift_q[MOD_W-1-j]};
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
      end
      r = trial[CNT_W-1:0];
    end
    step_rem = r;
  end

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    rem_d   = rem_q;
    div_d   = div_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      shift_d = MOD_W'(dividend_i);
      rem_d   = '0;
      div_d   = divisor_i;
    end else if (busy_q) begin
      rem_d   = step_rem;
      shift_d = shift_q << MOD_STEP_BITS;
      cnt_d   = cnt_q + 1'b1;
      if (cnt_q == MOD_CNT_W'(MOD_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
    div_q   <= div_d;
  end

  assign res_o.done = done_q;
  assign res_o.rem  = rem_q;

endmodule

`default_nettype wire

>>> hdl/dhoat_slot_mem.sv
// Slot store: stored keys and slot marks, one write and one registered read
// port each. Depends on dhoat_pkg.
`default_nettype none

module dhoat_slot_mem import dhoat_pkg::*; #(
  parameter int unsigned MAX_SLOTS = 1024,
  parameter int unsigned KEY_BITS  = 32,
  localparam int unsigned AW       = $clog2(MAX_SLOTS)
) (
  input  wire logic                clk_i,
  input  wire logic                we_mark_i,
  input  wire logic                we_key_i,
  input  wire logic [AW-1:0]       waddr_i,
  input  wire mark_e               wmark_i,
  input  wire logic [KEY_BITS-1:0] wkey_i,
  input  wire logic                re_i,
  input  wire logic [AW-1:0]       raddr_i,
  output mark_e                    rmark_o,
  output logic [KEY_BITS-1:0]      rkey_o
);

  mark_e               mark_mem [MAX_SLOTS];
  logic [KEY_BITS-1:0] key_mem  [MAX_SLOTS];

  always_ff @(posedge clk_i) begin
    if (we_mark_i) begin
      mark_mem[waddr_i] <= wmark_i;
    end
    if (re_i) begin
      rmark_o <= mark_mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_key_i) begin
      key_mem[waddr_i] <= wkey_i;
    end
    if (re_i) begin
      rkey_o <= key_mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/double_hash_open_address_table_unit.sv
// Top level of the double-hash open-address table: sequencer, probe datapath
// and stream ports. Depends on dhoat_pkg, dhoat_mod_unit and dhoat_slot_mem.
`default_nettype none

// Hash set with double hashing over up to MAX_SLOTS slots. After reset the
// block runs a clearing pass that marks every slot empty, and accepts no
// request until it ends; configuration writes are taken at all times. For
// a request, the shared remainder unit reduces the two hashes modulo the
// slot count one after the other at four bits per cycle, every probe of the
// slot store takes a read state and an evaluate state for the registered
// read, and a final state applies the update and loads the result once the
// output register is free.
// One request is in work at a time; a finished result waits in the output
// register while the next request is accepted.
module double_hash_open_address_table_unit import dhoat_pkg::*; #(
  parameter int unsigned MAX_SLOTS = 1024,
  parameter int unsigned KEY_BITS  = 32,
  localparam int unsigned IN_W     = ((REQ_W + KEY_BITS + 2 * HASH_W + 7) / 8) * 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CNT_W-1:0] cfg_data_i,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // req_type, key, first_hash, probe_step
  input  wire logic [IN_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  // status, found, entry_total, zero fill
  output logic [OUT_W-1:0]      m_axis_tdata_o
);

  localparam int unsigned AW      = $clog2(MAX_SLOTS);
  localparam int unsigned KEY_LSB = REQ_W;
  localparam int unsigned H1_LSB  = REQ_W + KEY_BITS;
  localparam int unsigned H2_LSB  = REQ_W + KEY_BITS + HASH_W;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_MOD1  = 7'b0000100,
    ST_MOD2  = 7'b0001000,
    ST_READ  = 7'b0010000,
    ST_EVAL  = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [CNT_W-1:0]    num_slots_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [REQ_W-1:0]    req_q, req_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [HASH_W-1:0]   h2_q, h2_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic [CNT_W-1:0]    pos_q, pos_d;
  logic [CNT_W-1:0]    step_q, step_d;
  logic [CNT_W-1:0]    iter_q, iter_d;
  logic                hit_q, hit_d;
  logic [CNT_W-1:0]    hit_pos_q, hit_pos_d;
  logic                free_q, free_d;
  logic [CNT_W-1:0]    free_pos_q, free_pos_d;
  logic                out_valid_q, out_valid_d;
  logic [OUT_W-1:0]    out_data_q, out_data_d;

  logic                in_fire;
  logic                out_free;
  logic [CNT_W-1:0]    n_active;
  logic                mod_start;
  logic [HASH_W-1:0]   mod_dividend;
  logic [CNT_W-1:0]    mod_divisor;
  mod_res_t            mod_res;

  logic                mem_we_mark, mem_we_key, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  mark_e               mem_wmark, mem_rmark;
  logic [KEY_BITS-1:0] mem_rkey;

  logic [CNT_W:0]      pos_sum;
  logic [CNT_W-1:0]    pos_next;
  logic [CNT_W-1:0]    iter_next;
  status_e             status_c;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_comb begin
    n_active = num_slots_q;
    if (num_slots_q == '0) begin
      n_active = CNT_W'(1);
    end else if (32'(num_slots_q) > MAX_SLOTS) begin
      n_active = CNT_W'(MAX_SLOTS);
    end
  end

  assign pos_sum   = {1'b0, pos_q} + {1'b0, step_q};
  assign pos_next  = (pos_sum >= {1'b0, n_q}) ? CNT_W'(pos_sum - {1'b0, n_q})
                                              : pos_sum[CNT_W-1:0];
  assign iter_next = iter_q + 1'b1;

  always_comb begin
    mod_start    = 1'b0;
    mod_dividend = h2_q;
    mod_divisor  = n_q;
    if (state_q == ST_IDLE) begin
      mod_start    = in_fire;
      mod_dividend = s_axis_tdata_i[H1_LSB +: HASH_W];
      mod_divisor  = n_active;
    end else if (state_q == ST_MOD1) begin
      mod_start = mod_res.done;
    end
  end

  dhoat_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .divisor_i  (mod_divisor),
    .res_o      (mod_res)
  );

  dhoat_slot_mem #(
    .MAX_SLOTS (MAX_SLOTS),
    .KEY_BITS  (KEY_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .we_mark_i (mem_we_mark),
    .we_key_i  (mem_we_key),
    .waddr_i   (mem_waddr),
    .wmark_i   (mem_wmark),
    .wkey_i    (key_q),
    .re_i      (mem_re),
    .raddr_i   (mem_raddr),
    .rmark_o   (mem_rmark),
    .rkey_o    (mem_rkey)
  );

  assign mem_re    = (state_q == ST_READ);
  assign mem_raddr = AW'(pos_q);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    count_d     = count_q;
    req_d       = req_q;
    key_d       = key_q;
    h2_d        = h2_q;
    n_d         = n_q;
    pos_d       = pos_q;
    step_d      = step_q;
    iter_d      = iter_q;
    hit_d       = hit_q;
    hit_pos_d   = hit_pos_q;
    free_d      = free_q;
    free_pos_d  = free_pos_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    mem_we_mark = 1'b0;
    mem_we_key  = 1'b0;
    mem_waddr   = clr_q;
    mem_wmark   = MARK_EMPTY;
    status_c    = STATUS_FAIL;

    case (state_q)
      ST_CLEAR: begin
        mem_we_mark = 1'b1;
        clr_d       = clr_q + 1'b1;
        if (clr_q == AW'(MAX_SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          req_d   = s_axis_tdata_i[REQ_W-1:0];
          key_d   = s_axis_tdata_i[KEY_LSB +: KEY_BITS];
          h2_d    = s_axis_tdata_i[H2_LSB +: HASH_W];
          n_d     = n_active;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          state_d = ST_MOD1;
        end
      end
      ST_MOD1: begin
        if (mod_res.done) begin
          pos_d   = mod_res.rem;
          state_d = ST_MOD2;
        end
      end
      ST_MOD2: begin
        if (mod_res.done) begin
          step_d  = mod_res.rem;
          iter_d  = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        iter_d  = iter_next;
        pos_d   = pos_next;
        state_d = (iter_next == n_q) ? ST_FIN : ST_READ;
        case (mem_rmark)
          MARK_EMPTY: begin
            if (!free_q) begin
              free_d     = 1'b1;
              free_pos_d = pos_q;
            end
            state_d = ST_FIN;
          end
          MARK_GONE: begin
            if (!free_q) begin
              free_d     = 1'b1;
              free_pos_d = pos_q;
            end
          end
          default: begin
            if (mem_rkey == key_q) begin
              hit_d     = 1'b1;
              hit_pos_d = pos_q;
              state_d   = ST_FIN;
            end
          end
        endcase
      end
      ST_FIN: begin
        case (req_q)
          REQ_INSERT: begin
            if (count_q >= n_q) begin
              status_c = STATUS_FAIL;
            end else if (hit_q) begin
              status_c = STATUS_DUP;
            end else if (free_q) begin
              status_c = STATUS_OK;
            end
          end
          REQ_REMOVE: begin
            status_c = hit_q ? STATUS_OK : STATUS_FAIL;
          end
          default: begin
            status_c = hit_q ? STATUS_OK : STATUS_FAIL;
          end
        endcase
        if (out_free) begin
          if (req_q == REQ_INSERT && status_c == STATUS_OK) begin
            mem_we_mark = 1'b1;
            mem_we_key  = 1'b1;
            mem_waddr   = AW'(free_pos_q);
            mem_wmark   = MARK_USED;
            count_d     = count_q + 1'b1;
          end else if (req_q == REQ_REMOVE && hit_q) begin
            mem_we_mark = 1'b1;
            mem_waddr   = AW'(hit_pos_q);
            mem_wmark   = MARK_GONE;
            if (count_q != '0) begin
              count_d = count_q - 1'b1;
            end
          end
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_data_d[OUT_STATUS_LSB +: STAT_W] = status_c;
          out_data_d[OUT_FOUND_BIT]            = hit_q;
          out_data_d[OUT_TOTAL_LSB +: CNT_W]   = count_d;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      num_slots_q <= NUM_SLOTS_RST;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        num_slots_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    key_q      <= key_d;
    h2_q       <= h2_d;
    n_q        <= n_d;
    pos_q      <= pos_d;
    step_q     <= step_d;
    iter_q     <= iter_d;
    hit_q      <= hit_d;
    hit_pos_q  <= hit_pos_d;
    free_q     <= free_d;
    free_pos_q <= free_pos_d;
    out_data_q <= out_data_d;
  end

endmodule

`default_nettype wire

>>> hdl/dhoat_checker.sv
// Port-level checks of the double-hash open-address table, and the bind
// that attaches them to the top level. Depends on dhoat_pkg.
`default_nettype none

module dhoat_checker import dhoat_pkg::*; #(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid_i,
  input wire logic             s_axis_tready_o,
  input wire logic             m_axis_tvalid_o,
  input wire logic             m_axis_tready_i,
  input wire logic [OUT_W-1:0] m_axis_tdata_o
);

  localparam int unsigned CNT_MAX = (MAX_SLOTS < 2047) ? MAX_SLOTS : 2047;

  logic [STAT_W-1:0] status;
  logic              found;
  logic [CNT_W-1:0]  total;

  assign status = m_axis_tdata_o[OUT_STATUS_LSB +: STAT_W];
  assign found  = m_axis_tdata_o[OUT_FOUND_BIT];
  assign total  = m_axis_tdata_o[OUT_TOTAL_LSB +: CNT_W];

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result transaction changed while stalled");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted while another one is in work");

  a_dup_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && status == STATUS_DUP |-> found)
    else $error("duplicate status without the key being present");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> status != 2'd3)
    else $error("unknown status code");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> 32'(total) <= CNT_MAX)
    else $error("occupied count beyond the slot capacity");

endmodule

bind double_hash_open_address_table_unit dhoat_checker #(
  .MAX_SLOTS (MAX_SLOTS)
) u_dhoat_checker (.*);

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for double_hash_open_address_table_unit: a directed table and random
// request phases over several slot counts, checked against a shadow copy of the table.
// Depends on dhoat_pkg and the RTL of the block only.

module testbench;
  import dhoat_pkg::*;

  localparam int unsigned IN_W = ((REQ_W + 32 + 2 * HASH_W + 7) / 8) * 8;
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned N_ROWS = 25;
  localparam int unsigned N_PHASES = 13;
  localparam int unsigned PHASE_ITEMS = 64;
  localparam int unsigned POOL_MAX = 40;
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  typedef struct packed {
    status_e          status;
    logic             found;
    logic [CNT_W-1:0] total;
  } reply_t;

  typedef enum logic [1:0] {
    ROW_REQ,
    ROW_CHK,
    ROW_CFG
  } row_e;

  typedef struct {
    row_e             kind;
    logic [CNT_W-1:0] slots;
    logic [REQ_W-1:0] rq;
    logic [31:0]      k;
    logic [30:0]      a;
    logic [30:0]      b;
    reply_t           want;
  } row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CNT_W-1:0] cfg_data_i;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  // req_type, key, first_hash, probe_step
  logic [IN_W-1:0]  s_axis_tdata_i;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i;
  // status, found, entry_total, zero fill
  logic [OUT_W-1:0] m_axis_tdata_o;

  logic [31:0]      shadow_key [TABLE_DEPTH];
  mark_e            shadow_mark [TABLE_DEPTH];
  int unsigned      shadow_count;
  logic [CNT_W-1:0] shadow_slots;

  reply_t           awaited [$];
  int unsigned      err_cnt = 0;
  int unsigned      checked_cnt = 0;
  int unsigned      cfg_cnt = 0;
  int unsigned      sent_by_req [4] = '{0, 0, 0, 0};
  int unsigned      seen_by_status [3] = '{0, 0, 0};
  int unsigned      tx_gap_max = 8;
  int unsigned      rx_stall_max = 8;
  bit               hold_long = 0;
  longint unsigned  cycle_cnt = 0;
  longint unsigned  cycle_budget = 4 * TABLE_DEPTH + 4 * LONG_HOLD + 5000;

  row_t script [N_ROWS] = '{
    '{ROW_CHK, 11'd0, REQ_LOOKUP, 32'h0000_0000, 31'h0, 31'h0, '{STATUS_FAIL, 1'b0, 11'd0}},
    '{ROW_CHK, 11'd0, REQ_REMOVE, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
      '{STATUS_FAIL, 1'b0, 11'd0}},
    '{ROW_CHK, 11'd0, REQ_INSERT, 32'h0000_0000, 31'h0, 31'h0, '{STATUS_OK, 1'b0, 11'd1}},
    '{ROW_CHK, 11'd0, REQ_INSERT, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
      '{STATUS_OK, 1'b0, 11'd2}},
    '{ROW_CHK, 11'd0, REQ_INSERT, 32'h0000_0000, 31'h0, 31'h0, '{STATUS_DUP, 1'b1, 11'd2}},
    '{ROW_CHK, 11'd0, REQ_SPARE, 32'h0000_0000, 31'h0, 31'h0, '{STATUS_OK, 1'b1, 11'd2}},
    '{ROW_CHK, 11'd0, REQ_LOOKUP, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
      '{STATUS_OK, 1'b1, 11'd2}},
    '{ROW_CHK, 11'd0, REQ_REMOVE, 32'h0000_0000, 31'h0, 31'h0, '{STATUS_OK, 1'b1, 11'd1}},
    '{ROW_CHK, 11'd0, REQ_LOOKUP, 32'h0000_0000, 31'h0, 31'h0, '{STATUS_FAIL, 1'b0, 11'd1}},
    '{ROW_CHK, 11'd0, REQ_INSERT, 32'h1234_5678, 31'h0, 31'h5, '{STATUS_OK, 1'b0, 11'd2}},
    '{ROW_CHK, 11'd0, REQ_LOOKUP, 32'h1234_5678, 31'h0, 31'h5, '{STATUS_OK, 1'b1, 11'd2}},
    '{ROW_CFG, 11'd0, REQ_LOOKUP, 32'h0, 31'h0, 31'h0, '{STATUS_OK, 1'b0, 11'd0}},
    '{ROW_CHK, 11'd0, REQ_INSERT, 32'hA5A5_A5A5, 31'h3, 31'h9, '{STATUS_FAIL, 1'b0, 11'd2}},
    '{ROW_CHK, 11'd0, REQ_LOOKUP, 32'h1234_5678, 31'h5555_5555, 31'h2AAA_AAAA,
      '{STATUS_OK, 1'b1, 11'd2}},
    '{ROW_CFG, 11'd2047, REQ_LOOKUP, 32'h0, 31'h0, 31'h0, '{STATUS_OK, 1'b0, 11'd0}},
    '{ROW_CHK, 11'd0, REQ_LOOKUP, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
      '{STATUS_OK, 1'b1, 11'd2}},
    '{ROW_CHK, 11'd0, REQ_REMOVE, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
      '{STATUS_OK, 1'b1, 11'd1}},
    '{ROW_CHK, 11'd0, REQ_REMOVE, 32'h1234_5678, 31'h0, 31'h5, '{STATUS_OK, 1'b1, 11'd0}},
    '{ROW_CFG, 11'd2, REQ_LOOKUP, 32'h0, 31'h0, 31'h0, '{STATUS_OK, 1'b0, 11'd0}},
    '{ROW_CHK, 11'd0, REQ_INSERT, 32'h0F0F_0F0F, 31'h1, 31'h0, '{STATUS_OK, 1'b0, 11'd1}},
    '{ROW_REQ, 11'd0, REQ_INSERT, 32'hF0F0_F0F0, 31'h1, 31'h0, '{STATUS_OK, 1'b0, 11'd0}},
    '{ROW_REQ, 11'd0, REQ_INSERT, 32'hF0F0_F0F0, 31'h1, 31'h1, '{STATUS_OK, 1'b0, 11'd0}},
    '{ROW_CHK, 11'd0, REQ_INSERT, 32'h3333_3333, 31'h0, 31'h1, '{STATUS_FAIL, 1'b0, 11'd2}},
    '{ROW_CHK, 11'd0, REQ_INSERT, 32'h0F0F_0F0F, 31'h0, 31'h1, '{STATUS_FAIL, 1'b1, 11'd2}},
    '{ROW_CFG, 11'd1024, REQ_LOOKUP, 32'h0, 31'h0, 31'h0, '{STATUS_OK, 1'b0, 11'd0}}
  };

  int unsigned phase_slots [N_PHASES] = '{7, 13, 1, 16, 31, 3, 64, 1024, 2, 50, 128, 11, 1000};

  double_hash_open_address_table_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [30:0] rand31();
    logic [31:0] r;
    r = $urandom();
    return r[30:0];
  endfunction

  function automatic int unsigned live_slots();
    if (shadow_slots == '0) return 1;
    if (shadow_slots > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(shadow_slots);
  endfunction

  function automatic int unsigned probe_slot(logic [30:0] a, logic [30:0] b, int unsigned i,
                                             int unsigned n);
    longint unsigned x;
    x = (64'(a) % 64'(n) + ((64'(b) % 64'(n)) * 64'(i)) % 64'(n)) % 64'(n);
    return int'(x);
  endfunction

  function automatic reply_t apply_request(logic [REQ_W-1:0] rq, logic [31:0] k,
                                           logic [30:0] a, logic [30:0] b);
    int unsigned n;
    int unsigned p;
    int hit;
    reply_t r;
    n = live_slots();
    hit = -1;
    for (int unsigned i = 0; i < n; i++) begin
      p = probe_slot(a, b, i, n);
      if (shadow_mark[p] == MARK_EMPTY) break;
      if (shadow_mark[p] == MARK_USED && shadow_key[p] == k) begin
        hit = int'(p);
        break;
      end
    end
    r.found = (hit >= 0);
    r.status = STATUS_FAIL;
    if (rq == REQ_INSERT) begin
      if (shadow_count >= n) begin
        r.status = STATUS_FAIL;
      end else if (hit >= 0) begin
        r.status = STATUS_DUP;
      end else begin
        for (int unsigned i = 0; i < n; i++) begin
          p = probe_slot(a, b, i, n);
          if (shadow_mark[p] != MARK_USED) begin
            shadow_mark[p] = MARK_USED;
            shadow_key[p] = k;
            shadow_count++;
            r.status = STATUS_OK;
            break;
          end
        end
      end
    end else if (rq == REQ_REMOVE) begin
      if (hit >= 0) begin
        shadow_mark[hit] = MARK_GONE;
        if (shadow_count > 0) shadow_count--;
        r.status = STATUS_OK;
      end
    end else begin
      r.status = (hit >= 0) ? STATUS_OK : STATUS_FAIL;
    end
    r.total = CNT_W'(shadow_count);
    return r;
  endfunction

  task automatic send_req(input logic [REQ_W-1:0] rq, input logic [31:0] k,
                          input logic [30:0] a, input logic [30:0] b,
                          input bit typed, input reply_t want);
    int unsigned gap;
    reply_t r;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i <= {b, a, k, rq};
    s_axis_tvalid_i <= 1'b1;
    cycle_budget += 4 * (2 * live_slots() + 60);
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    r = apply_request(rq, k, a, b);
    awaited.push_back(typed ? want : r);
    sent_by_req[rq]++;
  endtask

  task automatic drain_and_idle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_slots(input logic [CNT_W-1:0] v);
    drain_and_idle();
    @(negedge clk_i);
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    shadow_slots = v;
    cfg_cnt++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned stall;
    reply_t exp_r;
    logic [STAT_W-1:0] got_st;
    logic got_fd;
    logic [CNT_W-1:0] got_tot;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        m_axis_tready_i <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_long = 0;
      end else begin
        stall = $urandom_range(0, rx_stall_max);
        if (stall > 0) begin
          m_axis_tready_i <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      got_st = m_axis_tdata_o[OUT_STATUS_LSB +: STAT_W];
      got_fd = m_axis_tdata_o[OUT_FOUND_BIT];
      got_tot = m_axis_tdata_o[OUT_TOTAL_LSB +: CNT_W];
      if (awaited.size() == 0) begin
        err_cnt++;
        $display("%0t: reply with none awaited: status %0d found %0d total %0d",
                 $time, got_st, got_fd, got_tot);
      end else begin
        exp_r = awaited.pop_front();
        checked_cnt++;
        seen_by_status[exp_r.status]++;
        if (got_st != exp_r.status || got_fd != exp_r.found || got_tot != exp_r.total) begin
          err_cnt++;
          $display("%0t: mismatch: expected status %0d found %0d total %0d, got %0d %0d %0d",
                   $time, exp_r.status, exp_r.found, exp_r.total, got_st, got_fd, got_tot);
        end
      end
    end
  end

  initial begin
    while (cycle_cnt <= cycle_budget) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%0t: timeout after %0d cycles, %0d replies outstanding",
             $time, cycle_cnt, awaited.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [31:0] pool_key [POOL_MAX];
    logic [30:0] pool_a [POOL_MAX];
    logic [30:0] pool_b [POOL_MAX];
    int unsigned psz;
    int unsigned n;
    int unsigned j;
    int unsigned r;
    logic [REQ_W-1:0] rq;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    foreach (shadow_mark[i]) begin
      shadow_mark[i] = MARK_EMPTY;
      shadow_key[i] = '0;
    end
    shadow_count = 0;
    shadow_slots = NUM_SLOTS_RST;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int unsigned i = 0; i < N_ROWS; i++) begin
      if (script[i].kind == ROW_CFG) begin
        write_slots(script[i].slots);
      end else begin
        send_req(script[i].rq, script[i].k, script[i].a, script[i].b,
                 script[i].kind == ROW_CHK, script[i].want);
      end
    end

    for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
      write_slots(CNT_W'(phase_slots[ph]));
      n = live_slots();
      psz = (n * 3 / 2 + 2 > POOL_MAX) ? POOL_MAX : n * 3 / 2 + 2;
      for (int unsigned i = 0; i < psz; i++) begin
        pool_key[i] = $urandom();
        pool_a[i] = rand31();
        pool_b[i] = rand31();
      end
      tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      rx_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      if (ph == 3) begin
        tx_gap_max = 0;
        hold_long = 1;
      end
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 9);
        if (r < 8) begin
          j = $urandom_range(0, psz - 1);
          r = $urandom_range(0, 19);
          rq = (r < 9) ? REQ_INSERT : (r < 14) ? REQ_REMOVE : (r < 19) ? REQ_LOOKUP : REQ_SPARE;
          send_req(rq, pool_key[j], pool_a[j], pool_b[j], 1'b0, '0);
        end else begin
          rq = REQ_W'($urandom_range(0, 3));
          send_req(rq, $urandom(), rand31(), rand31(), 1'b0, '0);
        end
      end
    end

    drain_and_idle();
    repeat (50) @(posedge clk_i);
    $display("Sent %0d inserts, %0d removes, %0d lookups, %0d spare lookups over %0d slot counts.",
             sent_by_req[REQ_INSERT], sent_by_req[REQ_REMOVE], sent_by_req[REQ_LOOKUP],
             sent_by_req[REQ_SPARE], cfg_cnt);
    $display("Checked %0d replies (%0d done, %0d duplicate, %0d failed), %0d mismatches.",
             checked_cnt, seen_by_status[STATUS_OK], seen_by_status[STATUS_DUP],
             seen_by_status[STATUS_FAIL], err_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
